// ===== design/sed_pkg.sv =====
package sed_pkg;

    localparam int SAMPLE_W = 16;
    localparam int DELAY_W  = 14;
    localparam int GAIN_W   = 10;
    localparam int CFG_W    = 14;

    typedef logic [1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_DELAY  = 2'd0;
    localparam t_cfg_idx CFG_GAIN   = 2'd1;
    localparam t_cfg_idx CFG_STEREO = 2'd2;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] right_in;
        logic signed [SAMPLE_W-1:0] left_in;
    } t_in_req;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] right_out;
        logic signed [SAMPLE_W-1:0] left_out;
        logic                       saturated;
    } t_out_req;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       clamped;
    } t_lane_res;

endpackage

// ===== design/sed_ram.sv =====
module sed_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/sed_lane.sv =====
module sed_lane #(
    parameter int GAIN_FRACTION_BITS = 8
) (
    input  logic signed [sed_pkg::SAMPLE_W-1:0] i_dry,
    input  logic signed [sed_pkg::SAMPLE_W-1:0] i_delayed,
    input  logic signed [sed_pkg::GAIN_W-1:0]   i_gain,
    output sed_pkg::t_lane_res                  o_res
);
    import sed_pkg::*;

    localparam int F  = GAIN_FRACTION_BITS;
    localparam int PW = SAMPLE_W + GAIN_W;
    localparam int TW = 28 + F;
    localparam int QW = TW - F;
    localparam logic [TW-1:0]        ROUND_BIAS = TW'((64'd1 << F) - 64'd1);
    localparam logic signed [QW-1:0] SAT_MAX    = QW'(32767);
    localparam logic signed [QW-1:0] SAT_MIN    = -QW'(32768);

    logic signed [PW-1:0] prod;
    logic signed [TW-1:0] total;
    logic signed [TW-1:0] biased;
    logic signed [QW-1:0] quo;

    always_comb begin
        prod   = PW'(i_delayed) * PW'(i_gain);
        total  = (TW'(i_dry) <<< F) + TW'(prod);
        // Adding 2^F - 1 to a negative total makes the shift round toward zero.
        biased = total + (total[TW-1] ? $signed(ROUND_BIAS) : TW'(0));
        quo    = $signed(biased[TW-1:F]);
        if (quo > SAT_MAX) begin
            o_res.sample  = SAMPLE_W'(32767);
            o_res.clamped = 1'b1;
        end else if (quo < SAT_MIN) begin
            o_res.sample  = -SAMPLE_W'(32768);
            o_res.clamped = 1'b1;
        end else begin
            o_res.sample  = quo[SAMPLE_W-1:0];
            o_res.clamped = 1'b0;
        end
    end

endmodule

// ===== design/stereo_echo_delay_core.sv =====
// Channel  | Handshake                    | Payload
// ---------+------------------------------+--------------------------
// input    | i_in_valid / o_in_stall      | i_in_req  (t_in_req)
// output   | o_out_valid / i_out_stall    | o_out_req (t_out_req)
// config   | i_cfg_we                     | i_cfg_idx, i_cfg_data
//
// One frame per cycle is sustained while the output is not stalled; an accepted request
// passes the registered history read (the read stage), then the output register.
// Each history memory takes one write and one read per frame.
// Reset is synchronous; the history is not cleared, a fill count marks what was written.
// A stalled output holds its result; one more request is held in the read stage,
// then the input stalls.
module stereo_echo_delay_core #(
    parameter int HISTORY_DEPTH      = 16384,
    parameter int GAIN_FRACTION_BITS = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  sed_pkg::t_in_req          i_in_req,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output sed_pkg::t_out_req         o_out_req,
    input  logic                      i_cfg_we,
    input  sed_pkg::t_cfg_idx         i_cfg_idx,
    input  logic [sed_pkg::CFG_W-1:0] i_cfg_data
);
    import sed_pkg::*;

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int CW = AW + 1;
    localparam int XW = (AW > DELAY_W) ? AW + 1 : DELAY_W + 1;

    // Configuration.
    logic [DELAY_W-1:0]       r_delay;
    logic signed [GAIN_W-1:0] r_gain;
    logic                     r_stereo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay  <= '0;
            r_gain   <= '0;
            r_stereo <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DELAY:  r_delay  <= i_cfg_data[DELAY_W-1:0];
                CFG_GAIN:   r_gain   <= $signed(i_cfg_data[GAIN_W-1:0]);
                CFG_STEREO: r_stereo <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Handshake and pipeline control.
    logic r_s1_valid;
    logic r_out_valid;
    logic s1_adv;
    logic in_acc;

    assign s1_adv     = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign in_acc     = i_in_valid && !o_in_stall;

    // Address generation.
    logic [AW-1:0]           r_wp;
    logic [CW-1:0]           r_fill;
    logic [XW-1:0]           delay_x;
    logic [AW-1:0]           d_eff;
    logic [AW-1:0]           rp;
    logic [CW-1:0]           rp_wrap;
    logic signed [SAMPLE_W-1:0] left_dry;

    always_comb begin
        delay_x = XW'(r_delay);
        if (delay_x > XW'(HISTORY_DEPTH - 1)) begin
            d_eff = AW'(HISTORY_DEPTH - 1);
        end else begin
            d_eff = delay_x[AW-1:0];
        end
        rp_wrap = CW'(r_wp) + CW'(HISTORY_DEPTH) - CW'(d_eff);
        if (r_wp >= d_eff) begin
            rp = r_wp - d_eff;
        end else begin
            rp = rp_wrap[AW-1:0];
        end
        left_dry = r_stereo ? i_in_req.left_in : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_fill <= '0;
        end else if (in_acc) begin
            r_wp <= (r_wp == AW'(HISTORY_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            if (r_fill != CW'(HISTORY_DEPTH)) begin
                r_fill <= r_fill + 1'b1;
            end
        end
    end

    // History memories: write the dry frame and read the delayed one together.
    logic [SAMPLE_W-1:0] right_rd;
    logic [SAMPLE_W-1:0] left_rd;

    sed_ram #(
        .WIDTH(SAMPLE_W),
        .DEPTH(HISTORY_DEPTH)
    ) u_right_hist (
        .i_clk  (i_clk),
        .i_we   (in_acc),
        .i_waddr(r_wp),
        .i_wdata(i_in_req.right_in),
        .i_re   (in_acc),
        .i_raddr(rp),
        .o_rdata(right_rd)
    );

    sed_ram #(
        .WIDTH(SAMPLE_W),
        .DEPTH(HISTORY_DEPTH)
    ) u_left_hist (
        .i_clk  (i_clk),
        .i_we   (in_acc),
        .i_waddr(r_wp),
        .i_wdata(left_dry),
        .i_re   (in_acc),
        .i_raddr(rp),
        .o_rdata(left_rd)
    );

    // Read stage.
    logic signed [SAMPLE_W-1:0] r_s1_right;
    logic signed [SAMPLE_W-1:0] r_s1_left;
    logic                       r_s1_same;
    logic                       r_s1_hit;
    logic                       r_s1_stereo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_right  <= i_in_req.right_in;
            r_s1_left   <= left_dry;
            r_s1_same   <= (d_eff == '0);
            // An entry older than the frames seen since reset still reads as zero.
            r_s1_hit    <= (CW'(d_eff) <= r_fill);
            r_s1_stereo <= r_stereo;
        end
    end

    logic signed [SAMPLE_W-1:0] right_del;
    logic signed [SAMPLE_W-1:0] left_del;
    t_lane_res                  right_res;
    t_lane_res                  left_res;

    always_comb begin
        if (r_s1_same) begin
            right_del = r_s1_right;
            left_del  = r_s1_left;
        end else if (r_s1_hit) begin
            right_del = $signed(right_rd);
            left_del  = $signed(left_rd);
        end else begin
            right_del = '0;
            left_del  = '0;
        end
    end

    sed_lane #(
        .GAIN_FRACTION_BITS(GAIN_FRACTION_BITS)
    ) u_right_lane (
        .i_dry    (r_s1_right),
        .i_delayed(right_del),
        .i_gain   (r_gain),
        .o_res    (right_res)
    );

    sed_lane #(
        .GAIN_FRACTION_BITS(GAIN_FRACTION_BITS)
    ) u_left_lane (
        .i_dry    (r_s1_left),
        .i_delayed(left_del),
        .i_gain   (r_gain),
        .o_res    (left_res)
    );

    // Output register.
    t_out_req r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out.right_out <= right_res.sample;
            r_out.left_out  <= r_s1_stereo ? left_res.sample : '0;
            r_out.saturated <= right_res.clamped | (r_s1_stereo & left_res.clamped);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(HISTORY_DEPTH))
        else $error("fill count beyond history depth");

    a_wp_tracks_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill != CW'(HISTORY_DEPTH)) |-> (CW'(r_wp) == r_fill))
        else $error("write position out of step with fill count");

    a_adv_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_adv |=> r_out_valid)
        else $error("read stage advanced but no result is held");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_s1_valid)
        else $error("accepted request missing from read stage");

endmodule

// ===== tb/stereo_echo_delay_core_tb.sv =====
module stereo_echo_delay_core_tb;
    import sed_pkg::*;

    class echo_mix_board #(int DEPTH = 16384, int FRAC = 8);

        logic signed [SAMPLE_W-1:0] right_line [DEPTH];
        logic signed [SAMPLE_W-1:0] left_line  [DEPTH];
        int unsigned                head;
        logic [DELAY_W-1:0]         delay;
        logic signed [GAIN_W-1:0]   gain;
        logic                       stereo;
        t_out_req                   due_mixes [$];
        int                         errors;
        int                         frames;
        int                         clamps;
        int                         mono_frames;

        function new();
            foreach (right_line[i]) begin
                right_line[i] = '0;
                left_line[i]  = '0;
            end
            head   = 0;
            delay  = '0;
            gain   = '0;
            stereo = 1'b1;
        endfunction

        function void apply_reg(t_cfg_idx idx, logic [CFG_W-1:0] data);
            case (idx)
                CFG_DELAY:  delay  = data[DELAY_W-1:0];
                CFG_GAIN:   gain   = data[GAIN_W-1:0];
                CFG_STEREO: stereo = data[0];
                default: ;
            endcase
        endfunction

        function logic signed [SAMPLE_W-1:0] blend_sample(longint dry, longint delayed,
                                                          inout bit clamped);
            longint total;
            longint quot;
            total = dry * (longint'(1) << FRAC) + delayed * longint'(gain);
            // Signed division truncates toward zero, as the datapath must.
            quot  = total / (longint'(1) << FRAC);
            if (quot > 32767) begin
                clamped = 1'b1;
                quot    = 32767;
            end else if (quot < -32768) begin
                clamped = 1'b1;
                quot    = -32768;
            end
            return quot[SAMPLE_W-1:0];
        endfunction

        function void log_request(t_in_req req);
            int unsigned d;
            int unsigned rd;
            longint      r_dry;
            longint      l_dry;
            longint      r_del;
            longint      l_del;
            bit          clamped;
            t_out_req    mix;
            r_dry = req.right_in;
            l_dry = stereo ? longint'(req.left_in) : 0;
            d = delay;
            if (d > DEPTH - 1) begin
                d = DEPTH - 1;
            end
            rd = (head + DEPTH - d) % DEPTH;
            if (d == 0) begin
                r_del = r_dry;
                l_del = l_dry;
            end else begin
                r_del = right_line[rd];
                l_del = left_line[rd];
            end
            clamped       = 1'b0;
            mix.right_out = blend_sample(r_dry, r_del, clamped);
            mix.left_out  = stereo ? blend_sample(l_dry, l_del, clamped) : '0;
            mix.saturated = clamped;
            right_line[head] = r_dry[SAMPLE_W-1:0];
            left_line[head]  = l_dry[SAMPLE_W-1:0];
            head = (head + 1) % DEPTH;
            frames++;
            if (clamped) begin
                clamps++;
            end
            if (!stereo) begin
                mono_frames++;
            end
            due_mixes.push_back(mix);
        endfunction

        function void flag(string what, longint want, longint got);
            errors++;
            if (errors <= 40) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
            end
        endfunction

        function void match_result(t_out_req got);
            t_out_req want;
            if (due_mixes.size() == 0) begin
                errors++;
                if (errors <= 40) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, got);
                end
                return;
            end
            want = due_mixes.pop_front();
            if (got.right_out !== want.right_out) begin
                flag("right_out", want.right_out, got.right_out);
            end
            if (got.left_out !== want.left_out) begin
                flag("left_out", want.left_out, got.left_out);
            end
            if (got.saturated !== want.saturated) begin
                flag("saturated", want.saturated, got.saturated);
            end
        endfunction

        function int pending();
            return due_mixes.size();
        endfunction

    endclass

    localparam int       HISTORY_DEPTH      = 16384;
    localparam int       GAIN_FRACTION_BITS = 8;
    localparam t_cfg_idx CFG_SPARE          = 2'd3;
    localparam int       CYCLE_LIMIT        = 400000;
    localparam int       STEADY_FRAMES      = 400;
    localparam int       SHAPE_PHASES       = 8;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    t_in_req            i_in_req;
    logic               o_out_valid;
    logic               i_out_stall;
    t_out_req           o_out_req;
    logic               i_cfg_we;
    t_cfg_idx           i_cfg_idx;
    logic [CFG_W-1:0]   i_cfg_data;

    echo_mix_board #(HISTORY_DEPTH, GAIN_FRACTION_BITS) board;
    bit                 steady;
    int                 cycle_count;
    int                 settings_seen;

    stereo_echo_delay_core #(
        .HISTORY_DEPTH      (HISTORY_DEPTH),
        .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_req   (o_out_req),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("%0t: timeout with %0d results outstanding", $time, board.pending());
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            i_out_stall = i_rst_n && !steady && ($urandom_range(99) < 15);
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                board.match_result(o_out_req);
            end
        end
    end

    function automatic t_in_req make_frame(int right, int left);
        t_in_req f;
        f.right_in = right[SAMPLE_W-1:0];
        f.left_in  = left[SAMPLE_W-1:0];
        return f;
    endfunction

    function automatic int pick_sample();
        case ($urandom_range(9))
            0:       return 32767;
            1:       return -32768;
            2:       return $urandom_range(600) - 300;
            default: return $urandom_range(65535) - 32768;
        endcase
    endfunction

    task automatic push_frame(t_in_req req);
        @(negedge i_clk);
        while (!steady && $urandom_range(99) < 15) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_req   = req;
        do @(posedge i_clk); while (o_in_stall);
        board.log_request(req);
    endtask

    // Waits until every request has produced its result, then lets the
    // two-stage pipeline run empty before any register is touched.
    task automatic settle(int extra);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (board.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = data;
        board.apply_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
    endtask

    task automatic set_mode(int delay, int gain, bit stereo);
        logic [CFG_W-1:0] word;
        write_reg(CFG_DELAY, delay[DELAY_W-1:0]);
        // Bits above each register's width are random and must be ignored.
        word = CFG_W'($urandom);
        word[GAIN_W-1:0] = gain[GAIN_W-1:0];
        write_reg(CFG_GAIN, word);
        word = CFG_W'($urandom);
        word[0] = stereo;
        write_reg(CFG_STEREO, word);
        settings_seen++;
    endtask

    task automatic random_phase(int count);
        int delay;
        int gain;
        case ($urandom_range(5))
            0:       delay = 0;
            1:       delay = $urandom_range(1, 3);
            2:       delay = $urandom_range(4, 64);
            3:       delay = $urandom_range(65, 4000);
            4:       delay = HISTORY_DEPTH - 1;
            default: delay = $urandom_range(HISTORY_DEPTH - 1);
        endcase
        case ($urandom_range(4))
            0:       gain = -512;
            1:       gain = 511;
            2:       gain = 0;
            default: gain = $urandom_range(1023) - 512;
        endcase
        set_mode(delay, gain, $urandom_range(3) != 0);
        if ($urandom_range(2) == 0) begin
            write_reg(CFG_SPARE, CFG_W'($urandom));
        end
        repeat (count) push_frame(make_frame(pick_sample(), pick_sample()));
        settle(4);
    endtask

    initial begin
        board       = new();
        cycle_count = 0;
        steady      = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_req    = '0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = CFG_DELAY;
        i_cfg_data  = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset settings: no delay, no gain, stereo, so frames pass through.
        push_frame(make_frame(32767, -32768));
        push_frame(make_frame(-32768, 32767));
        push_frame(make_frame(0, 0));
        push_frame(make_frame(-1, 1));
        settle(4);

        // Zero delay reuses the current sample: clamps and truncation toward zero.
        set_mode(0, 511, 1'b1);
        push_frame(make_frame(32767, -32768));
        push_frame(make_frame(100, -100));
        push_frame(make_frame(-1, -1));
        settle(4);

        // Most negative gain with a short delay, reading back frames already in the history.
        set_mode(3, -512, 1'b1);
        push_frame(make_frame(-32768, 32767));
        push_frame(make_frame(32767, -32768));
        push_frame(make_frame(-32768, -32768));
        push_frame(make_frame(5, -5));
        push_frame(make_frame(1, 1));
        settle(4);

        // Mono mode, plus a write to an index past the register list.
        set_mode(1, 256, 1'b0);
        write_reg(CFG_SPARE, '1);
        push_frame(make_frame(32767, 32767));
        push_frame(make_frame(32767, -32768));
        push_frame(make_frame(-32768, 12345));
        push_frame(make_frame(-2, -1));
        settle(4);

        // Longest delay, with few frames seen since reset, still reads a zero echo.
        set_mode(HISTORY_DEPTH - 1, 256, 1'b1);
        push_frame(make_frame(32767, -32768));
        push_frame(make_frame(-32768, 32767));
        push_frame(make_frame(1234, -4321));
        settle(4);

        repeat (SHAPE_PHASES / 2) random_phase($urandom_range(100, 200));

        // One unbroken stream with no idling on either side, long enough for
        // its echoes to come back.
        steady = 1'b1;
        set_mode($urandom_range(20, 300), $urandom_range(1023) - 512, 1'b1);
        repeat (STEADY_FRAMES) push_frame(make_frame(pick_sample(), pick_sample()));
        settle(4);
        steady = 1'b0;

        repeat (SHAPE_PHASES / 2) random_phase($urandom_range(100, 200));
        settle(8);

        $display("Checked %0d frames under %0d register settings, with random stalls",
                 board.frames, settings_seen);
        $display("and one unbroken stream; %0d results clamped, %0d frames in mono mode.",
                 board.clamps, board.mono_frames);
        if (board.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
